### hdl/eorg_pkg.sv
// shared types, constants and shift helpers for the even onset rhythm generator
// no dependencies; used by eorg_ctrl, eorg_dp and even_onset_rhythm_generator
`default_nettype none

package eorg_pkg;

   localparam int MaxBeats  = 64;
   localparam int PatWidth  = 64;
   localparam int CntWidth  = 7;
   localparam int RotWidth  = 8;
   localparam int BitWidth  = 3;
   localparam int ReqWidth  = 24;
   localparam int RspWidth  = 72;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_ZERO_BEATS = 2'd1,
      ERR_TOO_MANY   = 2'd2
   } err_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MOD    = 7'b0000010,
      ST_MERGE  = 7'b0000100,
      ST_CONCAT = 7'b0001000,
      ST_TAIL   = 7'b0010000,
      ST_ROTATE = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic merge_step;
      logic concat_init;
      logic concat_step;
      logic tail_step;
      logic rotate;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic mod_last;
      logic merge_done;
      logic concat_more;
      logic tail_needed;
      logic out_free;
   } status_type;

   function automatic logic [PatWidth-1:0] shl64(input logic [PatWidth-1:0] v,
                                                 input logic [CntWidth-1:0] s);
      shl64 = (s >= CntWidth'(PatWidth)) ? '0 : (v << s);
   endfunction

   function automatic logic [PatWidth-1:0] shr64(input logic [PatWidth-1:0] v,
                                                 input logic [CntWidth-1:0] s);
      shr64 = (s >= CntWidth'(PatWidth)) ? '0 : (v >> s);
   endfunction

   function automatic logic [PatWidth-1:0] low_mask(input logic [CntWidth-1:0] n);
      low_mask = (n >= CntWidth'(PatWidth)) ? '1
                                            : ((PatWidth'(1) << n) - PatWidth'(1));
   endfunction

endpackage

`default_nettype wire

### hdl/eorg_ctrl.sv
// sequencing state machine for the even onset rhythm generator
// depends on eorg_pkg; drives the command struct of eorg_dp
`default_nettype none

module eorg_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  eorg_pkg::status_type  status,
   output eorg_pkg::cmd_type     cmd
);

   eorg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= eorg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         eorg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.special ? eorg_pkg::ST_FINISH : eorg_pkg::ST_MOD;
            end
         end
         eorg_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = eorg_pkg::ST_MERGE;
            end
         end
         eorg_pkg::ST_MERGE: begin
            if (status.merge_done) begin
               cmd.concat_init = 1'b1;
               state_in        = eorg_pkg::ST_CONCAT;
            end else begin
               cmd.merge_step = 1'b1;
            end
         end
         eorg_pkg::ST_CONCAT: begin
            if (status.concat_more) begin
               cmd.concat_step = 1'b1;
            end else if (status.tail_needed) begin
               state_in = eorg_pkg::ST_TAIL;
            end else begin
               state_in = eorg_pkg::ST_ROTATE;
            end
         end
         eorg_pkg::ST_TAIL: begin
            cmd.tail_step = 1'b1;
            state_in      = eorg_pkg::ST_ROTATE;
         end
         eorg_pkg::ST_ROTATE: begin
            cmd.rotate = 1'b1;
            state_in   = eorg_pkg::ST_FINISH;
         end
         eorg_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = eorg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = eorg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/eorg_dp.sv
// datapath: group merge registers, remainder unit, rotator and result register
// depends on eorg_pkg; commanded by eorg_ctrl
`default_nettype none

module eorg_dp (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [eorg_pkg::ReqWidth-1:0]       req_tdata,
   output logic [eorg_pkg::RspWidth-1:0]       rsp_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   input  eorg_pkg::cmd_type                   cmd,
   output eorg_pkg::status_type                status
);

   localparam int CW = eorg_pkg::CntWidth;
   localparam int PW = eorg_pkg::PatWidth;

   // input fields
   logic [CW-1:0]                   in_onsets;
   logic [CW-1:0]                   in_beats_raw;
   logic signed [eorg_pkg::RotWidth-1:0] in_rot;
   logic [CW-1:0]                   in_beats;

   // item registers
   logic [CW-1:0]                   beats_ff, beats_in;
   logic                            neg_ff, neg_in;
   logic [eorg_pkg::RotWidth-1:0]   mag_ff, mag_in;
   logic [CW-1:0]                   rem_ff, rem_in;
   logic [eorg_pkg::BitWidth-1:0]   bit_ff, bit_in;
   logic [CW-1:0]                   lead_cnt_ff, lead_cnt_in;
   logic [CW-1:0]                   lead_len_ff, lead_len_in;
   logic [PW-1:0]                   lead_val_ff, lead_val_in;
   logic [CW-1:0]                   rest_cnt_ff, rest_cnt_in;
   logic [CW-1:0]                   rest_len_ff, rest_len_in;
   logic [PW-1:0]                   rest_val_ff, rest_val_in;
   logic [PW-1:0]                   acc_ff, acc_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   eorg_pkg::err_type               err_ff, err_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                   rsp_pat_ff, rsp_pat_in;
   eorg_pkg::err_type               rsp_err_ff, rsp_err_in;

   logic [CW:0]                     rem_sh;
   logic [CW-1:0]                   amt;
   logic [PW-1:0]                   pat_m;
   logic [PW-1:0]                   mask;

   assign in_onsets    = req_tdata[6:0];
   assign in_beats_raw = req_tdata[13:7];
   assign in_rot       = req_tdata[21:14];
   assign in_beats     = (in_beats_raw > CW'(eorg_pkg::MaxBeats))
                         ? CW'(eorg_pkg::MaxBeats) : in_beats_raw;

   assign rem_sh = {rem_ff, mag_ff[bit_ff]};
   assign amt    = (neg_ff && rem_ff != '0) ? (beats_ff - rem_ff) : rem_ff;
   assign mask   = eorg_pkg::low_mask(beats_ff);
   assign pat_m  = acc_ff & mask;

   assign status.special     = (in_beats == '0) || (in_onsets == '0)
                               || (in_onsets > in_beats);
   assign status.mod_last    = (bit_ff == '0);
   assign status.merge_done  = !((rest_cnt_ff > CW'(1)) && (lead_cnt_ff != '0));
   assign status.concat_more = (idx_ff < lead_cnt_ff);
   assign status.tail_needed = (rest_cnt_ff != '0);
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      beats_in    = beats_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      rem_in      = rem_ff;
      bit_in      = bit_ff;
      lead_cnt_in = lead_cnt_ff;
      lead_len_in = lead_len_ff;
      lead_val_in = lead_val_ff;
      rest_cnt_in = rest_cnt_ff;
      rest_len_in = rest_len_ff;
      rest_val_in = rest_val_ff;
      acc_in      = acc_ff;
      idx_in      = idx_ff;
      err_in      = err_ff;
      rsp_pat_in  = rsp_pat_ff;
      rsp_err_in  = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.load) begin
         beats_in    = in_beats;
         neg_in      = in_rot[eorg_pkg::RotWidth-1];
         mag_in      = in_rot[eorg_pkg::RotWidth-1] ? (~in_rot + 1'b1) : in_rot;
         rem_in      = '0;
         bit_in      = '1;
         lead_cnt_in = in_onsets;
         lead_len_in = CW'(1);
         lead_val_in = PW'(1);
         rest_cnt_in = in_beats - in_onsets;
         rest_len_in = CW'(1);
         rest_val_in = '0;
         acc_in      = '0;
         err_in      = eorg_pkg::ERR_NONE;
         if (in_beats == '0) begin
            err_in = eorg_pkg::ERR_ZERO_BEATS;
         end else if (in_onsets > in_beats) begin
            acc_in = eorg_pkg::low_mask(in_beats);
            err_in = eorg_pkg::ERR_TOO_MANY;
         end
      end

      // one restoring step of |rotate| mod beats
      if (cmd.mod_step) begin
         bit_in = bit_ff - 1'b1;
         if (rem_sh >= {1'b0, beats_ff}) begin
            rem_in = CW'(rem_sh - {1'b0, beats_ff});
         end else begin
            rem_in = rem_sh[CW-1:0];
         end
      end

      if (cmd.merge_step) begin
         lead_val_in = eorg_pkg::shl64(lead_val_ff, rest_len_ff) | rest_val_ff;
         lead_len_in = lead_len_ff + rest_len_ff;
         if (lead_cnt_ff <= rest_cnt_ff) begin
            rest_cnt_in = rest_cnt_ff - lead_cnt_ff;
         end else begin
            rest_val_in = lead_val_ff;
            rest_cnt_in = lead_cnt_ff - rest_cnt_ff;
            rest_len_in = lead_len_ff;
            lead_cnt_in = rest_cnt_ff;
         end
      end

      if (cmd.concat_init) begin
         acc_in = lead_val_ff;
         idx_in = CW'(1);
      end

      if (cmd.concat_step) begin
         acc_in = eorg_pkg::shl64(acc_ff, lead_len_ff) | lead_val_ff;
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.tail_step) begin
         acc_in = eorg_pkg::shl64(acc_ff, rest_len_ff) | rest_val_ff;
      end

      if (cmd.rotate) begin
         acc_in = (eorg_pkg::shl64(pat_m, amt)
                   | eorg_pkg::shr64(pat_m, beats_ff - amt)) & mask;
      end

      if (cmd.out_load) begin
         rsp_pat_in   = acc_ff;
         rsp_err_in   = err_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beats_ff    <= beats_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      lead_cnt_ff <= lead_cnt_in;
      lead_len_ff <= lead_len_in;
      lead_val_ff <= lead_val_in;
      rest_cnt_ff <= rest_cnt_in;
      rest_len_ff <= rest_len_in;
      rest_val_ff <= rest_val_in;
      acc_ff      <= acc_in;
      idx_ff      <= idx_in;
      err_ff      <= err_in;
      rsp_pat_ff  <= rsp_pat_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_err_ff, rsp_pat_ff};

endmodule

`default_nettype wire

### hdl/even_onset_rhythm_generator.sv
// top level of the even onset rhythm generator: stream ports, controller and datapath
// depends on eorg_pkg, eorg_ctrl and eorg_dp
`default_nettype none

// Builds an evenly spread onset pattern (Bjorklund group merging) from an onset
// count, a beat count (saturated to 64) and a signed rotation, one item at a time.
// Zero beats, zero onsets and onsets above beats skip the merge and go straight
// from acceptance to the result load. Any other item steps through acceptance,
// the remainder of the rotation (one bit per cycle in a restoring unit), the merge
// steps, merge done with the first group, the group appends, appends done, a tail
// append when a remainder group is left, the rotate and the result load.
// The merge register set and its 64-bit shifter do one merge step per cycle.
// A finished result waits in its own register, so the next item is accepted
// while the previous result is still unread; the result load stalls only while
// that earlier result is still waiting.

module even_onset_rhythm_generator (
   input  wire                            clock,
   input  wire                            reset,
   // item in: [6:0] onset_count, [13:7] beat_count, [21:14] rotate_by, [23:22] zero
   input  wire  [eorg_pkg::ReqWidth-1:0]  req_tdata,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // item out: [63:0] pattern, [65:64] error_code, [71:66] zero
   output logic [eorg_pkg::RspWidth-1:0]  rsp_tdata,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready
);

   // command and status between sequencer and datapath
   eorg_pkg::cmd_type    cmd;
   eorg_pkg::status_type status;

   // sequencer: idle, remainder, merge, append, tail, rotate, load result
   eorg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath holds the item, the group registers and the result register
   eorg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

`ifndef ASSERT_OFF
   // one item at a time: after an item is taken the block is busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken twice in a row");

   // error code never takes the unused value
   a_err_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[65:64] != 2'b11))
      else $error("illegal error code");

   // zero beats always comes with an empty pattern
   a_zero_beats_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65:64] == eorg_pkg::ERR_ZERO_BEATS)
      |-> (rsp_tdata[63:0] == 64'd0))
      else $error("zero beats with nonzero pattern");

   // padding bits of the result stay clear
   a_pad_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[71:66] == 6'd0))
      else $error("result padding set");
`endif

endmodule

`default_nettype wire
